>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/qabc_pkg.sv
// ----------------------------------------------------------------------------
// qabc_pkg
// Types, widths and codes of the query admission budget controller.
// ----------------------------------------------------------------------------
package qabc_pkg;

   localparam int NUM_CLIENTS_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam int REQ_TYPE_W = 2;
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 32;
   localparam int SPACE_W    = 48;
   localparam int SEC_W      = 32;
   localparam int CONN_W     = 3;
   localparam int VERDICT_W  = 2;
   localparam int LIMIT_W    = 8;
   localparam int GRACE_W    = 8;
   localparam int PEND_W     = 10;
   localparam int CNT_W      = 9;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [GRACE_W-1:0] GRACE_RESET = 8'd15;

   localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_PROBE    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CHANGE   = 2'd2;

   localparam logic [CONN_W-1:0] CONN_PENDING  = 3'd0;
   localparam logic [CONN_W-1:0] CONN_READING  = 3'd1;
   localparam logic [CONN_W-1:0] CONN_RUNNING  = 3'd2;
   localparam logic [CONN_W-1:0] CONN_FINISHED = 3'd3;
   localparam logic [CONN_W-1:0] CONN_ZOMBIE   = 3'd4;

   localparam logic [VERDICT_W-1:0] VERDICT_WAIT    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_GRANTED = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_LIMITED = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_ACK     = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIENT_CAP      = 2'd0,
      CSR_AVAILABLE_TIME  = 2'd1,
      CSR_AVAILABLE_SPACE = 2'd2,
      CSR_GRACE_PERIOD    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      JOB_ADD    = 3'd0,
      JOB_PROBE  = 3'd1,
      JOB_CHANGE = 3'd2,
      JOB_ACK    = 3'd3,
      JOB_WAIT   = 3'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   time_need;
      logic [SPACE_W-1:0]  space_need;
      logic                locked;
      logic                in_grace;
      logic                release_budget;
      logic                to_running;
      logic                from_pending;
      logic                from_reading;
      logic                from_running;
   } job_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  client_cap;
      logic [TIME_W-1:0]   available_time;
      logic [SPACE_W-1:0]  available_space;
   } budget_cfg_type;

   typedef struct packed {
      logic [PEND_W-1:0]   pending;
      logic [CNT_W-1:0]    reading;
      logic [CNT_W-1:0]    running;
   } ctr_type;

endpackage

>>> rtl/qabc_if.sv
// ----------------------------------------------------------------------------
// qabc_req_if / qabc_rsp_if
// Valid/ready channels for request items and verdict items.
// ----------------------------------------------------------------------------
interface qabc_req_if;
   import qabc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SLOT_W-1:0]     client_slot;
   logic [TIME_W-1:0]     time_need;
   logic [SPACE_W-1:0]    space_need;
   logic [SEC_W-1:0]      now_seconds;
   logic [SEC_W-1:0]      first_seen_seconds;
   logic [CONN_W-1:0]     old_conn_state;
   logic [CONN_W-1:0]     new_conn_state;
   logic                  index_locked;

   modport source (
      output valid, req_type, client_slot, time_need, space_need, now_seconds,
             first_seen_seconds, old_conn_state, new_conn_state, index_locked,
      input  ready
   );
   modport sink (
      input  valid, req_type, client_slot, time_need, space_need, now_seconds,
             first_seen_seconds, old_conn_state, new_conn_state, index_locked,
      output ready
   );
endinterface

interface qabc_rsp_if;
   import qabc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink (input valid, verdict, output ready);
endinterface

>>> rtl/qabc_front.sv
// ----------------------------------------------------------------------------
// qabc_front
// Accepts request items and classifies them into jobs for the back end.
// ----------------------------------------------------------------------------
module qabc_front #(
   parameter int NUM_CLIENTS = qabc_pkg::NUM_CLIENTS_DEF
) (
   input  logic [qabc_pkg::GRACE_W-1:0] grace_period,
   qabc_req_if.sink                     req_ch,
   output logic                         push_valid,
   input  logic                         push_ready,
   output qabc_pkg::job_type            push_job
);
   import qabc_pkg::*;

   logic [SEC_W-1:0] elapsed;
   logic             slot_ok;

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      elapsed = req_ch.now_seconds - req_ch.first_seen_seconds;
      slot_ok = int'(req_ch.client_slot) < NUM_CLIENTS;

      push_job.slot           = req_ch.client_slot;
      push_job.time_need      = req_ch.time_need;
      push_job.space_need     = req_ch.space_need;
      push_job.locked         = req_ch.index_locked;
      push_job.in_grace       = elapsed < {{(SEC_W-GRACE_W){1'b0}}, grace_period};
      push_job.release_budget = (req_ch.old_conn_state == CONN_READING ||
                                 req_ch.old_conn_state == CONN_RUNNING) &&
                                (req_ch.new_conn_state == CONN_FINISHED ||
                                 req_ch.new_conn_state == CONN_ZOMBIE);
      push_job.to_running     = req_ch.new_conn_state == CONN_RUNNING;
      push_job.from_pending   = req_ch.old_conn_state == CONN_PENDING;
      push_job.from_reading   = req_ch.old_conn_state == CONN_READING;
      push_job.from_running   = req_ch.old_conn_state == CONN_RUNNING;

      case (req_ch.req_type)
         REQ_REGISTER: push_job.kind = slot_ok ? JOB_ADD : JOB_ACK;
         REQ_PROBE:    push_job.kind = slot_ok ? JOB_PROBE : JOB_WAIT;
         REQ_CHANGE:   push_job.kind = slot_ok ? JOB_CHANGE : JOB_ACK;
         default:      push_job.kind = JOB_ACK;
      endcase
   end

endmodule

>>> rtl/qabc_queue.sv
// ----------------------------------------------------------------------------
// qabc_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module qabc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  qabc_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output qabc_pkg::job_type head_job
);
   import qabc_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = fill_ff != FILL_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/qabc_back.sv
// ----------------------------------------------------------------------------
// qabc_back
// Executes jobs: client counter memory, budget reservations, verdict register.
// ----------------------------------------------------------------------------
module qabc_back #(
   parameter int NUM_CLIENTS = qabc_pkg::NUM_CLIENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  qabc_pkg::budget_cfg_type       cfg,
   input  logic                           job_valid,
   input  qabc_pkg::job_type              job,
   output logic                           job_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [qabc_pkg::VERDICT_W-1:0] rsp_verdict
);
   import qabc_pkg::*;

   localparam int IDX_W = $clog2(NUM_CLIENTS);

   typedef enum logic [1:0] {
      ST_FETCH = 2'b01,
      ST_EXEC  = 2'b10
   } back_state_type;

   back_state_type        state_ff, state_in;
   ctr_type               ctr_mem [NUM_CLIENTS];
   logic [NUM_CLIENTS-1:0] ctr_valid_ff;
   ctr_type               rd_data_ff;
   logic                  rd_valid_ff;
   logic                  fit_ff, fit_in;
   logic [TIME_W-1:0]     time_reserved_ff, time_reserved_in;
   logic [SPACE_W-1:0]    space_reserved_ff, space_reserved_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]  verdict_ff, verdict_in;

   logic [IDX_W-1:0]      idx;
   ctr_type               cur, upd;
   logic                  fire, wr_en;
   logic [TIME_W-1:0]     time_room;
   logic [SPACE_W-1:0]    space_room;
   logic [TIME_W:0]       time_sum;
   logic [SPACE_W:0]      space_sum;
   logic [TIME_W-1:0]     time_add_sat, time_sub_sat;
   logic [SPACE_W-1:0]    space_add_sat, space_sub_sat;
   logic                  limit_on, over_pend, over_active;
   logic [PEND_W-1:0]     active_sum;
   logic [PEND_W-1:0]     pend_inc, pend_dec;
   logic [CNT_W-1:0]      read_inc, read_dec, run_step, run_final;
   logic [VERDICT_W-1:0]  verdict_new;

   assign idx         = IDX_W'(job.slot);
   assign job_pop     = fire;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // budget headroom check, taken while the counter memory is read
   always_comb begin
      time_room  = cfg.available_time - time_reserved_ff;
      space_room = cfg.available_space - space_reserved_ff;
      fit_in = !job.locked &&
               (cfg.available_time >= time_reserved_ff) &&
               (job.time_need <= {1'b0, time_room[TIME_W-1:1]}) &&
               (cfg.available_space >= space_reserved_ff) &&
               (job.space_need <= {1'b0, space_room[SPACE_W-1:1]});
   end

   always_comb begin
      cur = rd_valid_ff ? rd_data_ff : '0;

      time_sum      = {1'b0, time_reserved_ff} + {1'b0, job.time_need};
      space_sum     = {1'b0, space_reserved_ff} + {1'b0, job.space_need};
      time_add_sat  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
      space_add_sat = space_sum[SPACE_W] ? '1 : space_sum[SPACE_W-1:0];
      time_sub_sat  = (time_reserved_ff > job.time_need) ?
                      time_reserved_ff - job.time_need : '0;
      space_sub_sat = (space_reserved_ff > job.space_need) ?
                      space_reserved_ff - job.space_need : '0;

      limit_on    = cfg.client_cap != '0;
      over_pend   = limit_on && (cur.pending >= {1'b0, cfg.client_cap, 1'b0});
      active_sum  = {1'b0, cur.reading} + {1'b0, cur.running};
      over_active = limit_on && (active_sum >= {2'b00, cfg.client_cap});

      pend_inc  = (cur.pending == '1) ? cur.pending : cur.pending + 1'b1;
      pend_dec  = (cur.pending == '0) ? '0 : cur.pending - 1'b1;
      read_inc  = (cur.reading == '1) ? cur.reading : cur.reading + 1'b1;
      read_dec  = (cur.reading == '0) ? '0 : cur.reading - 1'b1;
      run_step  = (job.to_running && cur.running != '1) ? cur.running + 1'b1 : cur.running;
      run_final = (job.from_running && run_step != '0) ? run_step - 1'b1 : run_step;

      upd               = cur;
      verdict_new       = VERDICT_ACK;
      time_reserved_in  = time_reserved_ff;
      space_reserved_in = space_reserved_ff;
      wr_en             = 1'b0;

      case (job.kind)
         JOB_ADD: begin
            upd.pending = pend_inc;
            wr_en       = 1'b1;
         end
         JOB_PROBE: begin
            wr_en = 1'b1;
            if (over_pend) begin
               verdict_new = VERDICT_LIMITED;
            end else if (over_active || !fit_ff) begin
               if (job.in_grace) begin
                  verdict_new = VERDICT_WAIT;
               end else begin
                  upd.pending = pend_dec;
                  verdict_new = VERDICT_LIMITED;
               end
            end else begin
               upd.pending       = pend_dec;
               upd.reading       = read_inc;
               time_reserved_in  = time_add_sat;
               space_reserved_in = space_add_sat;
               verdict_new       = VERDICT_GRANTED;
            end
         end
         JOB_CHANGE: begin
            wr_en       = 1'b1;
            upd.running = run_final;
            if (job.from_pending) begin
               upd.pending = pend_dec;
            end
            if (job.from_reading) begin
               upd.reading = read_dec;
            end
            if (job.release_budget) begin
               time_reserved_in  = time_sub_sat;
               space_reserved_in = space_sub_sat;
            end
         end
         JOB_WAIT: begin
            verdict_new = VERDICT_WAIT;
         end
         default: begin
            verdict_new = VERDICT_ACK;
         end
      endcase

      fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
      if (!fire) begin
         wr_en             = 1'b0;
         time_reserved_in  = time_reserved_ff;
         space_reserved_in = space_reserved_ff;
      end

      state_in = state_ff;
      case (state_ff)
         ST_FETCH: begin
            if (job_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      verdict_in   = verdict_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         verdict_in   = verdict_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_FETCH;
         time_reserved_ff  <= '0;
         space_reserved_ff <= '0;
         rsp_valid_ff      <= 1'b0;
         ctr_valid_ff      <= '0;
      end else begin
         state_ff          <= state_in;
         time_reserved_ff  <= time_reserved_in;
         space_reserved_ff <= space_reserved_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (wr_en) begin
            ctr_valid_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      if (state_ff == ST_FETCH) begin
         fit_ff <= fit_in;
      end
   end

   // counter memory: read in fetch, write back in execute
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ctr_mem[idx] <= upd;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff  <= ctr_mem[idx];
         rd_valid_ff <= ctr_valid_ff[idx];
      end
   end

endmodule

>>> rtl/query_admission_budget_control.sv
// ----------------------------------------------------------------------------
// query_admission_budget_control
// Admission controller for query requests against global time and space
// budgets with per-client rate limiting.
//
//   port     role     moves
//   req_ch   sink     request item (type, client, needs, times, states, lock)
//   rsp_ch   source   verdict item, one per request item
//   p*       slave    APB register writes and reads, 64-bit data
//
// In the back end each item gets a counter memory read at the queue head, then
// an update; the back end finishes one item before it fetches the next, while
// the queue goes on taking request items. Reset clears all client counters at
// once through per-client valid bits; no clearing pass. A full queue drops
// req_ch.ready; a verdict not taken holds the back end in its update cycle.
// ----------------------------------------------------------------------------
module query_admission_budget_control #(
   parameter int NUM_CLIENTS = qabc_pkg::NUM_CLIENTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   qabc_req_if.sink                        req_ch,
   qabc_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [qabc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [qabc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [qabc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import qabc_pkg::*;

   logic [LIMIT_W-1:0] client_cap_ff;
   logic [TIME_W-1:0]  available_time_ff;
   logic [SPACE_W-1:0] available_space_ff;
   logic [GRACE_W-1:0] grace_period_ff;
   csr_index_type      csr_index;
   logic               csr_write;
   budget_cfg_type     cfg;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   job_type            push_job, head_job;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_cap_ff      <= '0;
         available_time_ff  <= '0;
         available_space_ff <= '0;
         grace_period_ff    <= GRACE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLIENT_CAP:      client_cap_ff      <= pwdata[LIMIT_W-1:0];
            CSR_AVAILABLE_TIME:  available_time_ff  <= pwdata[TIME_W-1:0];
            CSR_AVAILABLE_SPACE: available_space_ff <= pwdata[SPACE_W-1:0];
            CSR_GRACE_PERIOD:    grace_period_ff    <= pwdata[GRACE_W-1:0];
            default:             client_cap_ff      <= client_cap_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_CLIENT_CAP:      prdata = CSR_DATA_W'(client_cap_ff);
         CSR_AVAILABLE_TIME:  prdata = CSR_DATA_W'(available_time_ff);
         CSR_AVAILABLE_SPACE: prdata = CSR_DATA_W'(available_space_ff);
         CSR_GRACE_PERIOD:    prdata = CSR_DATA_W'(grace_period_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      cfg.client_cap      = client_cap_ff;
      cfg.available_time  = available_time_ff;
      cfg.available_space = available_space_ff;
   end

   qabc_front #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_front (
      .grace_period (grace_period_ff),
      .req_ch       (req_ch),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_job     (push_job)
   );

   qabc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .head_job   (head_job)
   );

   qabc_back #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .job_valid   (pop_valid),
      .job         (head_job),
      .job_pop     (pop_ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_verdict (rsp_ch.verdict)
   );

endmodule

>>> rtl/qabc_checker.sv
// ----------------------------------------------------------------------------
// qabc_checker
// Port-level checks of the admission controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qabc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [qabc_pkg::VERDICT_W-1:0]  rsp_verdict,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [qabc_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [qabc_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [qabc_pkg::CSR_DATA_W-1:0] prdata
);
   import qabc_pkg::*;

   localparam int MAX_OPEN = QUEUE_DEPTH + 1;
   localparam int OPEN_W   = $clog2(MAX_OPEN + 1);

   logic [OPEN_W-1:0] open_ff, open_in;
   logic              req_take, rsp_take, wr_time, rd_time;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign wr_time  = psel && penable && pwrite &&
                     (paddr[CSR_ADDR_W-1:3] == CSR_AVAILABLE_TIME);
   assign rd_time  = psel && !pwrite && (paddr[CSR_ADDR_W-1:3] == CSR_AVAILABLE_TIME);
   assign open_in  = open_ff + OPEN_W'(req_take) - OPEN_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict), "verdict dropped or changed while stalled")
   `ASSERT_NOW(a_rsp_has_item, clock, reset, rsp_valid, open_ff != '0, "verdict without an open item")
   `ASSERT_NOW(a_full_stalls_req, clock, reset, open_ff == OPEN_W'(MAX_OPEN), !req_ready, "item taken while queue and verdict register are full")
   `ASSERT_NOW(a_time_readback, clock, reset, !$past(reset) && $past(wr_time) && rd_time, prdata == {32'h0, $past(pwdata[31:0])}, "time budget readback mismatch")

endmodule

bind query_admission_budget_control qabc_checker u_qabc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_verdict (rsp_ch.verdict),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);
